### hw/rtl/acfp_pkg.sv
`timescale 1ns / 1ps
// Package for the ASCII command frame parser.
// Holds the frame marks, field sizes, widths and the conversion phase type.
package acfp_pkg;

  localparam int NUM_FIELDS  = 5;
  localparam int FIELD_CHARS = 4;

  localparam int FIELD_IDX_W = $clog2(NUM_FIELDS);
  localparam int CHAR_CNT_W  = $clog2(FIELD_CHARS + 1);

  localparam int ADDR_W  = 14;
  localparam int VALUE_W = 15;
  localparam int MAG_W   = 14;
  localparam int ACC_W   = MAG_W + 4;
  localparam int MAG_MAX = 16383;

  localparam logic [7:0] MARK_FRAME = 8'h23;
  localparam logic [7:0] MARK_FIELD = 8'h24;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic [ADDR_W-1:0]  ADDR_RESET = 14'd10;
  localparam logic [VALUE_W-1:0] CMD_PLAIN  = 15'd1;
  localparam logic [VALUE_W-1:0] CMD_AUTO   = 15'd2;

  localparam int DIR_FIELD   = 2;
  localparam int MODE_FIELD  = 1;
  localparam int DIST_FIELD  = 3;
  localparam int TROUGH_FIELD = 4;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } conv_phase_t;

endpackage

### hw/rtl/acfp_digit_acc.sv
`timescale 1ns / 1ps
// Decimal accumulator step: value times ten plus one digit, on the magnitude.
// Saturates the magnitude and reapplies the sign. Uses acfp_pkg.
module acfp_digit_acc (
  input  logic signed [acfp_pkg::VALUE_W-1:0] value,
  input  logic                                negative,
  input  logic [3:0]                          digit,
  output logic signed [acfp_pkg::VALUE_W-1:0] result
);

  logic [acfp_pkg::VALUE_W-1:0] mag_full;
  logic [acfp_pkg::MAG_W-1:0]   mag;
  logic [acfp_pkg::ACC_W-1:0]   acc;
  logic [acfp_pkg::MAG_W-1:0]   sat;
  logic [acfp_pkg::VALUE_W-1:0] sat_ext;

  always_comb begin
    mag_full = negative ? -value : value;
    mag      = mag_full[acfp_pkg::MAG_W-1:0];
    acc      = (acfp_pkg::ACC_W'(mag) << 3) + (acfp_pkg::ACC_W'(mag) << 1)
             + acfp_pkg::ACC_W'(digit);
    if (acc > acfp_pkg::ACC_W'(acfp_pkg::MAG_MAX)) begin
      sat = acfp_pkg::MAG_W'(acfp_pkg::MAG_MAX);
    end else begin
      sat = acc[acfp_pkg::MAG_W-1:0];
    end
    sat_ext = {1'b0, sat};
    result  = negative ? $signed(-sat_ext) : $signed(sat_ext);
  end

endmodule

### hw/rtl/ascii_command_frame_parser.sv
`timescale 1ns / 1ps
// ASCII command frame parser, top level. Uses acfp_pkg and acfp_digit_acc.
// Every received word is echoed as one result word.
//
// Each received byte yields exactly one result word, registered in the cycle after
// it is taken; a new byte is taken every cycle unless the held result is
// stalled. '$' closes a field, '#' closes a frame; fields are converted like
// atoi with saturation at a magnitude of 16383. On '#', echo_repeat flags an
// address match, and cmd_valid flags a well-formed command; direction, and in
// auto mode distance and troughs, come with it. Overlong fields or too many
// fields mark the frame bad until its '#'. bot_address may be written only while idle.
module ascii_command_frame_parser (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [acfp_pkg::ADDR_W-1:0]          cfg_data,
  input  logic                                 rx_valid,
  output logic                                 rx_stall,
  input  logic [7:0]                           rx_byte,
  output logic                                 tx_valid,
  input  logic                                 tx_stall,
  output logic [7:0]                           echo_byte,
  output logic                                 echo_repeat,
  output logic                                 cmd_valid,
  output logic                                 cmd_mode,
  output logic [7:0]                           direction,
  output logic signed [acfp_pkg::VALUE_W-1:0]  distance,
  output logic signed [acfp_pkg::VALUE_W-1:0]  troughs
);

  logic [acfp_pkg::ADDR_W-1:0]         bot_address;
  logic signed [acfp_pkg::VALUE_W-1:0] field_value [acfp_pkg::NUM_FIELDS];
  logic [acfp_pkg::FIELD_IDX_W-1:0]    field_index, field_index_next;
  logic [acfp_pkg::CHAR_CNT_W-1:0]     char_count, char_count_next;
  acfp_pkg::conv_phase_t               conv_phase, conv_phase_next;
  logic                                negative_sign, negative_sign_next;
  logic [7:0]                          direction_char, direction_char_next;
  logic                                frame_bad, frame_bad_next;

  logic                                rx_take;
  logic                                fv_we;
  logic signed [acfp_pkg::VALUE_W-1:0] fv_wdata;
  logic signed [acfp_pkg::VALUE_W-1:0] cur_value;
  logic signed [acfp_pkg::VALUE_W-1:0] acc_value;
  logic                                cur_neg;
  acfp_pkg::conv_phase_t               cur_phase;
  logic                                first_char;
  logic                                is_digit;
  logic                                is_blank;
  logic                                is_sign;

  logic                                repeat_res;
  logic                                cmd_res;
  logic                                mode_res;
  logic [7:0]                          dir_res;
  logic signed [acfp_pkg::VALUE_W-1:0] dist_res;
  logic signed [acfp_pkg::VALUE_W-1:0] trough_res;

  assign rx_stall = tx_valid && tx_stall;
  assign rx_take  = rx_valid && !rx_stall;

  assign first_char = (char_count == '0);
  assign is_digit   = (rx_byte >= acfp_pkg::CHAR_ZERO) && (rx_byte <= acfp_pkg::CHAR_NINE);
  assign is_blank   = (rx_byte == acfp_pkg::CHAR_SPACE)
                   || ((rx_byte >= acfp_pkg::CHAR_TAB) && (rx_byte <= acfp_pkg::CHAR_CR));
  assign is_sign    = (rx_byte == acfp_pkg::CHAR_PLUS) || (rx_byte == acfp_pkg::CHAR_MINUS);

  assign cur_value = first_char ? '0 : field_value[field_index];
  assign cur_neg   = first_char ? 1'b0 : negative_sign;
  assign cur_phase = first_char ? acfp_pkg::PH_LEAD : conv_phase;

  acfp_digit_acc u_digit_acc (
    .value    (cur_value),
    .negative (cur_neg),
    .digit    (rx_byte[3:0]),
    .result   (acc_value)
  );

  // Next state of the field parser.
  always_comb begin
    field_index_next    = field_index;
    char_count_next     = char_count;
    conv_phase_next     = conv_phase;
    negative_sign_next  = negative_sign;
    direction_char_next = direction_char;
    frame_bad_next      = frame_bad;
    fv_we               = 1'b0;
    fv_wdata            = '0;
    if (rx_byte == acfp_pkg::MARK_FRAME) begin
      field_index_next   = '0;
      char_count_next    = '0;
      conv_phase_next    = acfp_pkg::PH_LEAD;
      negative_sign_next = 1'b0;
      frame_bad_next     = 1'b0;
    end else if (frame_bad) begin
      frame_bad_next = 1'b1;
    end else if (rx_byte == acfp_pkg::MARK_FIELD) begin
      if (first_char) begin
        fv_we = 1'b1;
        if (field_index == acfp_pkg::FIELD_IDX_W'(acfp_pkg::DIR_FIELD)) begin
          direction_char_next = '0;
        end
      end
      if (field_index == acfp_pkg::FIELD_IDX_W'(acfp_pkg::NUM_FIELDS - 1)) begin
        frame_bad_next = 1'b1;
      end else begin
        field_index_next = field_index + 1'b1;
      end
      char_count_next    = '0;
      conv_phase_next    = acfp_pkg::PH_LEAD;
      negative_sign_next = 1'b0;
    end else if (char_count >= acfp_pkg::CHAR_CNT_W'(acfp_pkg::FIELD_CHARS)) begin
      frame_bad_next = 1'b1;
    end else begin
      fv_we              = first_char;
      negative_sign_next = cur_neg;
      conv_phase_next    = cur_phase;
      if (first_char && field_index == acfp_pkg::FIELD_IDX_W'(acfp_pkg::DIR_FIELD)) begin
        direction_char_next = rx_byte;
      end
      char_count_next = char_count + 1'b1;
      unique case (cur_phase)
        acfp_pkg::PH_LEAD: begin
          if (is_blank) begin
            conv_phase_next = acfp_pkg::PH_LEAD;
          end else if (is_sign) begin
            negative_sign_next = (rx_byte == acfp_pkg::CHAR_MINUS);
            conv_phase_next    = acfp_pkg::PH_DIGITS;
          end else if (is_digit) begin
            fv_we           = 1'b1;
            fv_wdata        = acc_value;
            conv_phase_next = acfp_pkg::PH_DIGITS;
          end else begin
            conv_phase_next = acfp_pkg::PH_DONE;
          end
        end
        acfp_pkg::PH_DIGITS: begin
          if (is_digit) begin
            fv_we    = 1'b1;
            fv_wdata = acc_value;
          end else begin
            conv_phase_next = acfp_pkg::PH_DONE;
          end
        end
        default: begin
          conv_phase_next = cur_phase;
        end
      endcase
    end
  end

  // Result of the current word.
  always_comb begin
    repeat_res = (rx_byte == acfp_pkg::MARK_FRAME)
              && (field_value[0] == $signed({1'b0, bot_address}));
    cmd_res    = repeat_res && !first_char && !frame_bad
              && ((field_value[acfp_pkg::MODE_FIELD] == acfp_pkg::CMD_PLAIN)
               || (field_value[acfp_pkg::MODE_FIELD] == acfp_pkg::CMD_AUTO));
    mode_res   = cmd_res && (field_value[acfp_pkg::MODE_FIELD] == acfp_pkg::CMD_AUTO);
    dir_res    = cmd_res ? direction_char : '0;
    dist_res   = mode_res ? field_value[acfp_pkg::DIST_FIELD] : '0;
    trough_res = mode_res ? field_value[acfp_pkg::TROUGH_FIELD] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bot_address <= acfp_pkg::ADDR_RESET;
    end else if (cfg_write) begin
      bot_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < acfp_pkg::NUM_FIELDS; i++) begin
        field_value[i] <= '0;
      end
      field_index    <= '0;
      char_count     <= '0;
      conv_phase     <= acfp_pkg::PH_LEAD;
      negative_sign  <= 1'b0;
      direction_char <= '0;
      frame_bad      <= 1'b0;
    end else if (rx_take) begin
      if (fv_we) begin
        field_value[field_index] <= fv_wdata;
      end
      field_index    <= field_index_next;
      char_count     <= char_count_next;
      conv_phase     <= conv_phase_next;
      negative_sign  <= negative_sign_next;
      direction_char <= direction_char_next;
      frame_bad      <= frame_bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (rx_take) begin
      tx_valid <= 1'b1;
    end else if (!tx_stall) begin
      tx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      echo_byte   <= rx_byte;
      echo_repeat <= repeat_res;
      cmd_valid   <= cmd_res;
      cmd_mode    <= mode_res;
      direction   <= dir_res;
      distance    <= dist_res;
      troughs     <= trough_res;
    end
  end

  a_cmd_on_frame_end: assert property (@(posedge clk) disable iff (rst)
    tx_valid && cmd_valid |-> echo_repeat && (echo_byte == acfp_pkg::MARK_FRAME))
    else $error("command issued without a matched frame end");

  a_idle_payload: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !cmd_valid |-> (direction == '0) && (distance == '0) && (troughs == '0))
    else $error("command fields set without a command");

  a_echo_follows: assert property (@(posedge clk) disable iff (rst)
    rx_take |=> tx_valid && (echo_byte == $past(rx_byte)))
    else $error("taken word not echoed in the next cycle");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    field_index <= acfp_pkg::FIELD_IDX_W'(acfp_pkg::NUM_FIELDS - 1))
    else $error("field index beyond the last field");

endmodule
